>>> rtl/gcf_pkg.sv
// gcf_pkg: shared types, codes and helpers for the gripper force controller.
// No dependencies.
`timescale 1ns / 1ps
package gcf_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_STIFFNESS   = 3'd0,
    REG_PROP_GAIN       = 3'd1,
    REG_INT_GAIN_DT     = 3'd2,
    REG_FORCE_TARGET    = 3'd3,
    REG_CONTACT_THRESH  = 3'd4,
    REG_SUM_RESET_THR   = 3'd5,
    REG_INTEGRAL_LIMIT  = 3'd6,
    REG_CONTROL_RATE    = 3'd7
  } cfg_reg_t;

  localparam logic [1:0] MODE_TRAJ  = 2'd0;
  localparam logic [1:0] MODE_TRANS = 2'd1;
  localparam logic [1:0] MODE_FORCE = 2'd2;

  localparam logic [1:0] CONTACT_NONE = 2'd0;
  localparam logic [1:0] CONTACT_GOT  = 2'd1;
  localparam logic [1:0] CONTACT_IN   = 2'd2;

  // datapath operation issued by the controller each cycle
  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_LOAD   = 4'd1,
    OP_UPDATE = 4'd2,
    OP_ACC    = 4'd3,
    OP_PMUL   = 4'd4,
    OP_IMUL   = 4'd5,
    OP_DRIVE  = 4'd6,
    OP_VEL    = 4'd7,
    OP_VSAT   = 4'd8,
    OP_COMMIT = 4'd9
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic force_path;
  } dp_status_t;

  localparam logic signed [65:0] SAT_HI = 66'sh0_0000_0000_7FFF_FFFF;
  localparam logic signed [65:0] SAT_LO = 66'sh3_FFFF_FFFF_8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) r = 32'sh7FFF_FFFF;
    else if (v < SAT_LO) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> rtl/gcf_in_if.sv
// gcf_in_if: tick/goal channel with valid/ready handshake.
// No dependencies.
`timescale 1ns / 1ps
interface gcf_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic               goal_closing;
  logic               goal_active;
  logic        [15:0] force_a;
  logic        [15:0] force_b;
  logic signed [31:0] pos_a;
  logic signed [31:0] pos_b;
  logic signed [31:0] traj_pos_a;
  logic signed [31:0] traj_pos_b;
  logic signed [31:0] traj_vel_a;
  logic signed [31:0] traj_vel_b;

  modport source (output valid, cmd, goal_closing, goal_active, force_a, force_b,
                  pos_a, pos_b, traj_pos_a, traj_pos_b, traj_vel_a, traj_vel_b,
                  input ready);
  modport sink (input valid, cmd, goal_closing, goal_active, force_a, force_b,
                pos_a, pos_b, traj_pos_a, traj_pos_b, traj_vel_a, traj_vel_b,
                output ready);
endinterface

>>> rtl/gcf_out_if.sv
// gcf_out_if: drive result channel with valid/ready handshake.
// No dependencies.
`timescale 1ns / 1ps
interface gcf_out_if;
  logic               valid;
  logic               ready;
  logic               drive_valid;
  logic signed [31:0] des_pos_a;
  logic signed [31:0] des_pos_b;
  logic signed [31:0] des_vel_a;
  logic signed [31:0] des_vel_b;
  logic        [1:0]  mode;
  logic        [1:0]  contact_a;
  logic        [1:0]  contact_b;

  modport source (output valid, drive_valid, des_pos_a, des_pos_b, des_vel_a, des_vel_b,
                  mode, contact_a, contact_b, input ready);
  modport sink (input valid, drive_valid, des_pos_a, des_pos_b, des_vel_a, des_vel_b,
                mode, contact_a, contact_b, output ready);
endinterface

>>> rtl/gcf_ctrl.sv
// gcf_ctrl: sequencer for the force controller datapath and output handshake.
// Depends on gcf_pkg.
`timescale 1ns / 1ps
module gcf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  gcf_pkg::dp_status_t status,
  output gcf_pkg::dp_cmd_t    cmd
);
  import gcf_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_UPD  = 9'b000000010,
    S_ACC  = 9'b000000100,
    S_PMUL = 9'b000001000,
    S_IMUL = 9'b000010000,
    S_DRV  = 9'b000100000,
    S_VEL  = 9'b001000000,
    S_VSAT = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd.op = OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.op = OP_UPDATE;
        state_next = status.force_path ? S_ACC : S_DONE;
      end
      S_ACC: begin
        cmd.op = OP_ACC;
        state_next = S_PMUL;
      end
      S_PMUL: begin
        cmd.op = OP_PMUL;
        state_next = S_IMUL;
      end
      S_IMUL: begin
        cmd.op = OP_IMUL;
        state_next = S_DRV;
      end
      S_DRV: begin
        cmd.op = OP_DRIVE;
        state_next = S_VEL;
      end
      S_VEL: begin
        cmd.op = OP_VEL;
        state_next = S_VSAT;
      end
      S_VSAT: begin
        cmd.op = OP_VSAT;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.op = OP_COMMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == OP_COMMIT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

>>> rtl/gcf_dp.sv
// gcf_dp: contact tracking, mode logic and PI arithmetic on one shared multiplier.
// Depends on gcf_pkg.
`timescale 1ns / 1ps
module gcf_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gcf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gcf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  gcf_pkg::dp_cmd_t                cmd,
  output gcf_pkg::dp_status_t             status,
  input  logic                            cmd_in,
  input  logic                            goal_closing,
  input  logic                            goal_active,
  input  logic        [15:0]              force_a,
  input  logic        [15:0]              force_b,
  input  logic signed [31:0]              pos_a,
  input  logic signed [31:0]              pos_b,
  input  logic signed [31:0]              traj_pos_a,
  input  logic signed [31:0]              traj_pos_b,
  input  logic signed [31:0]              traj_vel_a,
  input  logic signed [31:0]              traj_vel_b,
  output logic                            drive_valid,
  output logic signed [31:0]              des_pos_a,
  output logic signed [31:0]              des_pos_b,
  output logic signed [31:0]              des_vel_a,
  output logic signed [31:0]              des_vel_b,
  output logic        [1:0]               mode,
  output logic        [1:0]               contact_a,
  output logic        [1:0]               contact_b
);
  import gcf_pkg::*;

  // configuration
  logic [30:0] inv_stiffness, prop_gain, int_gain_dt, integral_limit;
  logic [16:0] force_target, sum_reset_threshold;
  logic [15:0] contact_threshold, control_rate;

  // latched beat
  logic               l_cmd, l_closing, l_active;
  logic        [15:0] l_force [2];
  logic signed [31:0] l_pos [2];
  logic signed [31:0] l_tpos [2];
  logic signed [31:0] l_tvel [2];

  // controller state
  logic        [1:0]  finger_contact [2];
  logic        [15:0] prev_force [2];
  logic signed [31:0] contact_pos [2];
  logic        [1:0]  ctrl_mode;
  logic               closing_flag;
  logic signed [31:0] error_accum;
  logic        [16:0] prev_force_sum;
  logic signed [31:0] prev_drive;

  // working registers
  logic               clear_int;
  logic signed [31:0] df, acc_r, u_r;
  logic signed [63:0] pisum;
  logic signed [64:0] prod;

  // staged result
  logic               st_valid;
  logic signed [31:0] st_pos [2];
  logic signed [31:0] st_vel [2];
  logic        [1:0]  st_mode;

  // update-step combinational values
  logic        [16:0] fsum;
  logic        [1:0]  fc_new [2];
  logic signed [31:0] cp_new [2];
  logic        [1:0]  mode_new;
  logic signed [17:0] ferr;

  always_comb begin
    fsum = {1'b0, l_force[0]} + {1'b0, l_force[1]};
    for (int i = 0; i < 2; i++) begin
      fc_new[i] = finger_contact[i];
      if (l_force[i] > contact_threshold)
        fc_new[i] = (prev_force[i] <= contact_threshold) ? CONTACT_GOT : CONTACT_IN;
      cp_new[i] = contact_pos[i];
      if (finger_contact[i] == CONTACT_NONE && fc_new[i] != CONTACT_NONE)
        cp_new[i] = l_pos[i];
    end
    mode_new = ctrl_mode;
    if (ctrl_mode == MODE_TRANS) mode_new = MODE_FORCE;
    else if (ctrl_mode == MODE_TRAJ && fc_new[0] != CONTACT_NONE &&
             fc_new[1] != CONTACT_NONE && closing_flag)
      mode_new = MODE_TRANS;
    ferr = $signed({1'b0, force_target}) - $signed({1'b0, fsum});
  end

  assign status.force_path = !l_cmd && l_active && (mode_new == MODE_FORCE);

  // shared multiplier operands
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_UPDATE: begin
        mul_a = {{15{ferr[17]}}, ferr};
        mul_b = $signed({1'b0, inv_stiffness});
      end
      OP_PMUL: begin
        mul_a = $signed({2'b00, prop_gain});
        mul_b = df;
      end
      OP_IMUL: begin
        mul_a = $signed({2'b00, int_gain_dt});
        mul_b = acc_r;
      end
      OP_VEL: begin
        mul_a = 33'(u_r) - 33'(prev_drive);
        mul_b = $signed({16'd0, control_rate});
      end
      default: ;
    endcase
  end

  // accumulate step
  logic signed [31:0] df_sat;
  logic signed [33:0] acc_sum, lim34;
  logic signed [31:0] acc_new;

  always_comb begin
    df_sat = sat32(66'(prod));
    acc_sum = 34'(error_accum) + 34'(df_sat);
    lim34 = $signed({3'b000, integral_limit});
    if (acc_sum > lim34) acc_sum = lim34;
    if (acc_sum < -lim34) acc_sum = -lim34;
    acc_new = clear_int ? 32'sd0 : acc_sum[31:0];
  end

  // drive step: u = floor(-pi / 2^17), saturated
  logic signed [65:0] pi_full, pi_neg;
  logic signed [31:0] u_new;

  always_comb begin
    pi_full = 66'(pisum) + 66'(prod);
    pi_neg = -pi_full;
    u_new = sat32(pi_neg >>> 17);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_stiffness <= 31'd65536;
      prop_gain <= '0;
      int_gain_dt <= '0;
      force_target <= '0;
      contact_threshold <= '0;
      sum_reset_threshold <= '0;
      integral_limit <= 31'h7FFF_FFFF;
      control_rate <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_INV_STIFFNESS:  inv_stiffness <= cfg_data;
        REG_PROP_GAIN:      prop_gain <= cfg_data;
        REG_INT_GAIN_DT:    int_gain_dt <= cfg_data;
        REG_FORCE_TARGET:   force_target <= cfg_data[16:0];
        REG_CONTACT_THRESH: contact_threshold <= cfg_data[15:0];
        REG_SUM_RESET_THR:  sum_reset_threshold <= cfg_data[16:0];
        REG_INTEGRAL_LIMIT: integral_limit <= cfg_data;
        REG_CONTROL_RATE:   control_rate <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        finger_contact[i] <= CONTACT_NONE;
        prev_force[i] <= '0;
        contact_pos[i] <= '0;
      end
      ctrl_mode <= MODE_TRAJ;
      closing_flag <= 1'b0;
      error_accum <= '0;
      prev_force_sum <= '0;
      prev_drive <= '0;
    end else begin
      case (cmd.op)
        OP_UPDATE: begin
          if (l_cmd) begin
            closing_flag <= l_closing;
            ctrl_mode <= MODE_TRAJ;
            for (int i = 0; i < 2; i++) begin
              contact_pos[i] <= '0;
              finger_contact[i] <= CONTACT_NONE;
            end
          end else begin
            ctrl_mode <= mode_new;
            for (int i = 0; i < 2; i++) begin
              finger_contact[i] <= fc_new[i];
              contact_pos[i] <= cp_new[i];
              prev_force[i] <= l_force[i];
            end
            prev_force_sum <= fsum;
          end
        end
        OP_ACC: error_accum <= acc_new;
        OP_VEL: prev_drive <= u_r;
        default: ;
      endcase
    end
  end

  // payload path
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (cmd.op)
      OP_LOAD: begin
        l_cmd <= cmd_in;
        l_closing <= goal_closing;
        l_active <= goal_active;
        l_force[0] <= force_a;
        l_force[1] <= force_b;
        l_pos[0] <= pos_a;
        l_pos[1] <= pos_b;
        l_tpos[0] <= traj_pos_a;
        l_tpos[1] <= traj_pos_b;
        l_tvel[0] <= traj_vel_a;
        l_tvel[1] <= traj_vel_b;
      end
      OP_UPDATE: begin
        clear_int <= (prev_force_sum >= sum_reset_threshold) &&
                     (fsum < sum_reset_threshold);
        st_valid <= 1'b0;
        for (int i = 0; i < 2; i++) begin
          st_pos[i] <= '0;
          st_vel[i] <= '0;
        end
        if (l_cmd) begin
          st_mode <= MODE_TRAJ;
        end else begin
          st_mode <= mode_new;
          if (l_active && mode_new != MODE_FORCE) begin
            st_valid <= 1'b1;
            for (int i = 0; i < 2; i++) begin
              st_pos[i] <= (fc_new[i] != CONTACT_NONE && closing_flag) ? cp_new[i]
                                                                        : l_tpos[i];
              st_vel[i] <= l_tvel[i];
            end
          end
        end
      end
      OP_ACC: begin
        df <= df_sat;
        acc_r <= acc_new;
      end
      OP_IMUL: pisum <= prod[63:0];
      OP_DRIVE: u_r <= u_new;
      OP_VEL: begin
        for (int i = 0; i < 2; i++) st_pos[i] <= sat32(66'(l_pos[i]) + 66'(u_r));
      end
      OP_VSAT: begin
        st_valid <= 1'b1;
        for (int i = 0; i < 2; i++) st_vel[i] <= sat32(66'(prod));
      end
      OP_COMMIT: begin
        drive_valid <= st_valid;
        des_pos_a <= st_pos[0];
        des_pos_b <= st_pos[1];
        des_vel_a <= st_vel[0];
        des_vel_b <= st_vel[1];
        mode <= st_mode;
        contact_a <= finger_contact[0];
        contact_b <= finger_contact[1];
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/gripper_contact_force_pi_control.sv
// gripper_contact_force_pi_control: top level of the two-finger gripper controller.
// Depends on gcf_pkg, gcf_in_if, gcf_out_if, gcf_ctrl, gcf_dp.
//
// Usage:
//   tick  - input channel; one beat is a control tick (cmd 0) or a new goal
//           (cmd 1) with forces, measured and trajectory positions/velocities.
//   drive - output channel; exactly one result beat per input beat, in order.
//   cfg_* - register writes (cfg_index selects the register); write only while idle, not enforced by the block.
// Sequence: a trajectory tick, inactive tick or new goal passes IDLE, UPD and
//   DONE; a force-control tick passes IDLE, UPD, ACC, PMUL, IMUL, DRV, VEL, VSAT
//   and DONE. The force path runs four products (force error, P term, I term,
//   velocity) through one 33x32 multiplier in sequence.
// Flow: one beat in flight; tick.ready is high only in idle, so the next beat is
//   accepted only after the last one has been committed to the output register.
// The result sits in an output register; the next beat is accepted while it
//   waits, and that beat's result is held back until drive is taken.
// Reset (rst, synchronous): registers go to defaults, contacts to none,
//   mode to trajectory, integral and histories to zero, no result pending.
`timescale 1ns / 1ps
module gripper_contact_force_pi_control (
  input  logic                           clk,
  input  logic                           rst,
  gcf_in_if.sink                         tick,
  gcf_out_if.source                      drive,
  input  logic                           cfg_we,
  input  logic [gcf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gcf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gcf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: owns handshakes and issues one datapath op per cycle
  gcf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tick.valid),
    .in_ready  (tick.ready),
    .out_valid (drive.valid),
    .out_ready (drive.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: state, staged result and output register
  gcf_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .cmd_in       (tick.cmd),
    .goal_closing (tick.goal_closing),
    .goal_active  (tick.goal_active),
    .force_a      (tick.force_a),
    .force_b      (tick.force_b),
    .pos_a        (tick.pos_a),
    .pos_b        (tick.pos_b),
    .traj_pos_a   (tick.traj_pos_a),
    .traj_pos_b   (tick.traj_pos_b),
    .traj_vel_a   (tick.traj_vel_a),
    .traj_vel_b   (tick.traj_vel_b),
    .drive_valid  (drive.drive_valid),
    .des_pos_a    (drive.des_pos_a),
    .des_pos_b    (drive.des_pos_b),
    .des_vel_a    (drive.des_vel_a),
    .des_vel_b    (drive.des_vel_b),
    .mode         (drive.mode),
    .contact_a    (drive.contact_a),
    .contact_b    (drive.contact_b)
  );

endmodule

>>> rtl/gcf_checker.sv
// gcf_checker: port-level assertions for the gripper controller, bound to the top.
// Depends on gcf_pkg and gripper_contact_force_pi_control.
`timescale 1ns / 1ps
module gcf_port_asserts (
  input logic               clk,
  input logic               rst,
  input logic               tick_valid,
  input logic               tick_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               drive_valid,
  input logic signed [31:0] des_pos_a,
  input logic        [1:0]  mode,
  input logic        [1:0]  contact_a,
  input logic        [1:0]  contact_b
);
  import gcf_pkg::*;

  // result beat holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("drive valid dropped before ready");

  // one beat at a time: after an accept the input side closes
  a_busy: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> !tick_ready)
    else $error("tick accepted while busy");

  // undriven results carry zero positions
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !drive_valid |-> des_pos_a == 32'sd0)
    else $error("invalid drive with nonzero position");

  // codes on the result are legal
  a_codes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mode == MODE_TRAJ || mode == MODE_TRANS || mode == MODE_FORCE) &&
      (contact_a == CONTACT_NONE || contact_a == CONTACT_GOT || contact_a == CONTACT_IN) &&
      (contact_b == CONTACT_NONE || contact_b == CONTACT_GOT || contact_b == CONTACT_IN))
    else $error("illegal mode or contact code");

endmodule

bind gripper_contact_force_pi_control gcf_port_asserts u_gcf_port_asserts (
  .clk         (clk),
  .rst         (rst),
  .tick_valid  (tick.valid),
  .tick_ready  (tick.ready),
  .out_valid   (drive.valid),
  .out_ready   (drive.ready),
  .drive_valid (drive.drive_valid),
  .des_pos_a   (drive.des_pos_a),
  .mode        (drive.mode),
  .contact_a   (drive.contact_a),
  .contact_b   (drive.contact_b)
);
